@@ rtl/wall_segment_intersect_table_defines.svh @@
// Assertion macros used by the checker file.
`ifndef WALL_SEGMENT_INTERSECT_TABLE_DEFINES_SVH
`define WALL_SEGMENT_INTERSECT_TABLE_DEFINES_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ rtl/wst_pkg.sv @@
// Package: operation codes and the crossing status type of the wall segment table.
`timescale 1ns / 1ps
package wst_pkg;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_SEG_QUERY = 2'd1,
        OP_PT_QUERY  = 2'd2
    } t_op;

    typedef struct packed {
        logic busy;
        logic valid;
        logic hit;
    } t_xing_status;

endpackage

@@ rtl/wst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/wst_cross.sv @@
// Pipelined strict-ccw crossing test of one stored wall against the query segment.
`timescale 1ns / 1ps
module wst_cross
    import wst_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wall_valid,
    input  logic [4*COORD_BITS-1:0]      i_wall,
    input  logic signed [COORD_BITS-1:0] i_qsx,
    input  logic signed [COORD_BITS-1:0] i_qsy,
    input  logic signed [COORD_BITS-1:0] i_qex,
    input  logic signed [COORD_BITS-1:0] i_qey,
    output t_xing_status                 o_status
);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;

    logic signed [CB-1:0] wsx, wsy, wex, wey;
    logic signed [DW-1:0] e_qsx, e_qsy, e_qex, e_qey, e_wsx, e_wsy, e_wex, e_wey;

    assign wsx = $signed(i_wall[4*CB-1:3*CB]);
    assign wsy = $signed(i_wall[3*CB-1:2*CB]);
    assign wex = $signed(i_wall[2*CB-1:CB]);
    assign wey = $signed(i_wall[CB-1:0]);

    assign e_qsx = DW'(i_qsx);
    assign e_qsy = DW'(i_qsy);
    assign e_qex = DW'(i_qex);
    assign e_qey = DW'(i_qey);
    assign e_wsx = DW'(wsx);
    assign e_wsy = DW'(wsy);
    assign e_wex = DW'(wex);
    assign e_wey = DW'(wey);

    // stage 1: differences
    logic                 r_v1;
    logic signed [DW-1:0] r_qey_wsy, r_qsx_wsx, r_qsy_wsy, r_qex_wsx;
    logic signed [DW-1:0] r_qey_wey, r_qsx_wex, r_qsy_wey, r_qex_wex;
    logic signed [DW-1:0] r_wex_wsx, r_wey_wsy;

    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_p1l, r_p1r, r_p2l, r_p2r, r_p3l, r_p3r, r_p4l, r_p4r;

    // stage 3: crossing flag
    logic                 r_v3;
    logic                 r_hit;
    logic                 c1, c2, c3, c4;

    assign c1 = r_p1l > r_p1r;
    assign c2 = r_p2l > r_p2r;
    assign c3 = r_p3l > r_p3r;
    assign c4 = r_p4l > r_p4r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_wall_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qey_wsy <= e_qey - e_wsy;
        r_qsx_wsx <= e_qsx - e_wsx;
        r_qsy_wsy <= e_qsy - e_wsy;
        r_qex_wsx <= e_qex - e_wsx;
        r_qey_wey <= e_qey - e_wey;
        r_qsx_wex <= e_qsx - e_wex;
        r_qsy_wey <= e_qsy - e_wey;
        r_qex_wex <= e_qex - e_wex;
        r_wex_wsx <= e_wex - e_wsx;
        r_wey_wsy <= e_wey - e_wsy;

        r_p1l <= PW'(r_qey_wsy) * PW'(r_qsx_wsx);
        r_p1r <= PW'(r_qsy_wsy) * PW'(r_qex_wsx);
        r_p2l <= PW'(r_qey_wey) * PW'(r_qsx_wex);
        r_p2r <= PW'(r_qsy_wey) * PW'(r_qex_wex);
        r_p3l <= PW'(r_qsy_wsy) * PW'(r_wex_wsx);
        r_p3r <= PW'(r_wey_wsy) * PW'(r_qsx_wsx);
        r_p4l <= PW'(r_qey_wsy) * PW'(r_wex_wsx);
        r_p4r <= PW'(r_wey_wsy) * PW'(r_qex_wsx);

        r_hit <= (c1 != c2) && (c3 != c4);
    end

    assign o_status.busy  = r_v1 | r_v2;
    assign o_status.valid = r_v3;
    assign o_status.hit   = r_hit;
endmodule

@@ rtl/wall_segment_intersect_table.sv @@
// Top level: wall segment table with crossing and bounding-box queries.
//
//  channel   handshake              payload
//  command   start, busy            i_operation, i_ax, i_ay, i_bx, i_by
//  result    o_strobe (one cycle)   o_hits_wall, o_outside_field, o_table_full
//
// Append and point query: busy stays low, result in the cycle after the transaction.
// Segment query: busy while the stored walls are scanned, result in the cycle after
// busy ends; one stored wall per cycle through the single RAM read port and the
// product pipeline. Writes happen only while busy is low, so reads and writes of
// one entry never overlap. Synchronous reset, no clearing pass; results are never
// stalled.
`timescale 1ns / 1ps
module wall_segment_intersect_table
    import wst_pkg::*;
#(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output logic                         o_strobe,
    output logic                         o_hits_wall,
    output logic                         o_outside_field,
    output logic                         o_table_full
);
    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam int CB = COORD_BITS;
    localparam int WW = 4 * CB;
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state               r_state;
    logic [CW-1:0]        r_count, r_addr;
    logic signed [CB-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [CB-1:0] r_qsx, r_qsy, r_qex, r_qey;
    logic                 r_rd_valid;
    logic                 r_hit;
    logic                 r_strobe, r_hits, r_outside, r_full;

    logic                 accept, issue, full, we, done, outside;
    logic [WW-1:0]        rdata;
    t_xing_status         xs;
    logic signed [CB-1:0] lo_x, hi_x, lo_y, hi_y;

    assign busy    = (r_state == ST_SCAN);
    assign accept  = start && !busy;
    assign full    = (r_count >= CW'(MAX_WALLS));
    assign we      = accept && (t_op'(i_operation) == OP_APPEND) && !full;
    assign issue   = busy && (r_addr < r_count);
    assign done    = busy && !issue && !r_rd_valid && !xs.busy && !xs.valid;
    assign outside = (i_ax > r_max_x) || (i_ax < r_min_x) ||
                     (i_ay > r_max_y) || (i_ay < r_min_y);

    assign lo_x = (i_ax < i_bx) ? i_ax : i_bx;
    assign hi_x = (i_ax > i_bx) ? i_ax : i_bx;
    assign lo_y = (i_ay < i_by) ? i_ay : i_by;
    assign hi_y = (i_ay > i_by) ? i_ay : i_by;

    wst_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_WALLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_ax, i_ay, i_bx, i_by}),
        .i_re    (issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    wst_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wall_valid (r_rd_valid),
        .i_wall       (rdata),
        .i_qsx        (r_qsx),
        .i_qsy        (r_qsy),
        .i_qex        (r_qex),
        .i_qey        (r_qey),
        .o_status     (xs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_addr     <= '0;
            r_min_x    <= C_MAX;
            r_min_y    <= C_MAX;
            r_max_x    <= C_MIN;
            r_max_y    <= C_MIN;
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_strobe   <= 1'b0;
            r_hits     <= 1'b0;
            r_outside  <= 1'b0;
            r_full     <= 1'b0;
        end else begin
            r_strobe   <= 1'b0;
            r_rd_valid <= issue;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_operation)
                            OP_APPEND: begin
                                r_strobe  <= 1'b1;
                                r_hits    <= 1'b0;
                                r_outside <= 1'b0;
                                r_full    <= full;
                                if (!full) begin
                                    r_count <= r_count + 1'b1;
                                    if (lo_x < r_min_x) r_min_x <= lo_x;
                                    if (hi_x > r_max_x) r_max_x <= hi_x;
                                    if (lo_y < r_min_y) r_min_y <= lo_y;
                                    if (hi_y > r_max_y) r_max_y <= hi_y;
                                end
                            end
                            OP_SEG_QUERY: begin
                                r_state <= ST_SCAN;
                                r_addr  <= '0;
                                r_hit   <= 1'b0;
                            end
                            OP_PT_QUERY: begin
                                r_strobe  <= 1'b1;
                                r_hits    <= 1'b0;
                                r_outside <= outside;
                                r_full    <= 1'b0;
                            end
                            default: begin
                                r_strobe  <= 1'b1;
                                r_hits    <= 1'b0;
                                r_outside <= 1'b0;
                                r_full    <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (xs.valid && xs.hit) begin
                        r_hit <= 1'b1;
                    end
                    if (done) begin
                        r_state   <= ST_IDLE;
                        r_strobe  <= 1'b1;
                        r_hits    <= r_hit;
                        r_outside <= 1'b0;
                        r_full    <= 1'b0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // query payload
    always_ff @(posedge i_clk) begin
        if (accept && (t_op'(i_operation) == OP_SEG_QUERY)) begin
            r_qsx <= i_ax;
            r_qsy <= i_ay;
            r_qex <= i_bx;
            r_qey <= i_by;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_hits_wall     = r_hits;
    assign o_outside_field = r_outside;
    assign o_table_full    = r_full;
endmodule

@@ rtl/wst_checker.sv @@
// Port-level checker for the wall segment table, bound to the top level.
`timescale 1ns / 1ps
`include "wall_segment_intersect_table_defines.svh"
module wst_checker
    import wst_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_strobe,
    input logic       o_hits_wall,
    input logic       o_outside_field,
    input logic       o_table_full
);
    `ASSERT_NEXT(a_quick_result, start && !busy && i_operation != OP_SEG_QUERY, o_strobe)
    `ASSERT_NEXT(a_query_busy, start && !busy && i_operation == OP_SEG_QUERY, busy)
    `ASSERT_SAME(a_one_flag, o_strobe, $onehot0({o_hits_wall, o_outside_field, o_table_full}))
    `ASSERT_SAME(a_hit_after_scan, o_strobe && o_hits_wall, $past(busy))
    `ASSERT_SAME(a_idle_on_result, o_strobe, !busy)
endmodule

bind wall_segment_intersect_table wst_checker u_wst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_operation     (i_operation),
    .o_strobe        (o_strobe),
    .o_hits_wall     (o_hits_wall),
    .o_outside_field (o_outside_field),
    .o_table_full    (o_table_full)
);
